>>> rtl/imhpq_pkg.sv
package imhpq_pkg;

    // identifier space and input field layout
    localparam int ID_W       = 10;
    localparam int ID_SPACE   = 1024;
    localparam int OP_W       = 2;
    localparam int KEY_IN_W   = 32;
    localparam int IN_W       = 48;
    localparam int ST_W       = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_DECR    = 2'd1;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [ST_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [ST_W-1:0] ST_PRESENT = 3'd4;

    // heap read address selects
    localparam logic [2:0] HRD_ROOT   = 3'd0;
    localparam logic [2:0] HRD_LAST   = 3'd1;
    localparam logic [2:0] HRD_SLOT   = 3'd2;
    localparam logic [2:0] HRD_PARENT = 3'd3;
    localparam logic [2:0] HRD_LEFT   = 3'd4;
    localparam logic [2:0] HRD_RIGHT  = 3'd5;

    // datapath register actions
    localparam logic [3:0] ACT_NONE      = 4'd0;
    localparam logic [3:0] ACT_PUSH_INIT = 4'd1;
    localparam logic [3:0] ACT_SLOT      = 4'd2;
    localparam logic [3:0] ACT_E_IN      = 4'd3;
    localparam logic [3:0] ACT_EX_MIN    = 4'd4;
    localparam logic [3:0] ACT_E_RD      = 4'd5;
    localparam logic [3:0] ACT_PLACE     = 4'd6;
    localparam logic [3:0] ACT_UP        = 4'd7;
    localparam logic [3:0] ACT_LCAP      = 4'd8;
    localparam logic [3:0] ACT_DN        = 4'd9;

    // controller to datapath commands
    typedef struct packed {
        logic            load;
        logic            clr_step;
        logic            map_rd;
        logic            hrd;
        logic [2:0]      hrd_sel;
        logic [3:0]      act;
        logic            set_st;
        logic [ST_W-1:0] st;
        logic            res_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic            clr_done;
        logic            map_valid;
        logic            full;
        logic            cnt_zero;
        logic            pos_zero;
        logic            less_dk;
        logic            less_up;
        logic            left_in;
        logic            dn_move;
        logic            out_busy;
        logic [OP_W-1:0] op;
    } sts_t;

endpackage

>>> rtl/imhpq_ctrl.sv
module imhpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  imhpq_pkg::sts_t   sts,
    output imhpq_pkg::cmd_t   cmd,
    input  logic              in_valid,
    output logic              in_ready
);
    import imhpq_pkg::*;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_MAP_RD  = 4'd2;
    localparam logic [3:0] S_MAP_CHK = 4'd3;
    localparam logic [3:0] S_DK_CHK  = 4'd4;
    localparam logic [3:0] S_EX_RD0  = 4'd5;
    localparam logic [3:0] S_EX_RD1  = 4'd6;
    localparam logic [3:0] S_EX_LAST = 4'd7;
    localparam logic [3:0] S_UP_RD   = 4'd8;
    localparam logic [3:0] S_UP_CMP  = 4'd9;
    localparam logic [3:0] S_DN_RDL  = 4'd10;
    localparam logic [3:0] S_DN_RDR  = 4'd11;
    localparam logic [3:0] S_DN_CMP  = 4'd12;
    localparam logic [3:0] S_FIN     = 4'd13;
    localparam logic [3:0] S_FIN2    = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.act    = ACT_NONE;
        cmd.st     = ST_DONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    // route a fresh item by its operation
                    unique case (sts.op)
                        OP_PUSH, OP_DECR: state_next = S_MAP_RD;
                        OP_EXTRACT:       state_next = S_EX_RD0;
                        OP_LOOKUP:        state_next = S_FIN;
                        default:          state_next = S_FIN;
                    endcase
                end
            end
            S_MAP_RD:
            begin
                cmd.map_rd = 1'b1;
                state_next = S_MAP_CHK;
            end
            S_MAP_CHK:
            begin
                if (sts.op == OP_PUSH)
                begin
                    if (sts.map_valid)
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ST_PRESENT;
                        state_next = S_FIN;
                    end
                    else if (sts.full)
                    begin
                        cmd.set_st = 1'b1;
                        cmd.st     = ST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.act    = ACT_PUSH_INIT;
                        state_next = S_UP_RD;
                    end
                end
                else if (!sts.map_valid)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_ABSENT;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.act     = ACT_SLOT;
                    cmd.hrd     = 1'b1;
                    cmd.hrd_sel = HRD_SLOT;
                    state_next  = S_DK_CHK;
                end
            end
            S_DK_CHK:
            begin
                if (sts.less_dk)
                begin
                    cmd.act    = ACT_E_IN;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EX_RD0:
            begin
                if (sts.cnt_zero)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_EMPTY;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.hrd     = 1'b1;
                    cmd.hrd_sel = HRD_ROOT;
                    state_next  = S_EX_RD1;
                end
            end
            S_EX_RD1:
            begin
                cmd.act     = ACT_EX_MIN;
                cmd.hrd     = 1'b1;
                cmd.hrd_sel = HRD_LAST;
                state_next  = S_EX_LAST;
            end
            S_EX_LAST:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.act    = ACT_E_RD;
                    state_next = S_DN_RDL;
                end
            end
            S_UP_RD:
            begin
                if (sts.pos_zero)
                begin
                    cmd.act    = ACT_PLACE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.hrd     = 1'b1;
                    cmd.hrd_sel = HRD_PARENT;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.less_up)
                begin
                    cmd.act    = ACT_UP;
                    state_next = S_UP_RD;
                end
                else
                begin
                    cmd.act    = ACT_PLACE;
                    state_next = S_FIN;
                end
            end
            S_DN_RDL:
            begin
                if (sts.left_in)
                begin
                    cmd.hrd     = 1'b1;
                    cmd.hrd_sel = HRD_LEFT;
                    state_next  = S_DN_RDR;
                end
                else
                begin
                    cmd.act    = ACT_PLACE;
                    state_next = S_FIN;
                end
            end
            S_DN_RDR:
            begin
                cmd.act     = ACT_LCAP;
                cmd.hrd     = 1'b1;
                cmd.hrd_sel = HRD_RIGHT;
                state_next  = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (sts.dn_move)
                begin
                    cmd.act    = ACT_DN;
                    state_next = S_DN_RDL;
                end
                else
                begin
                    cmd.act    = ACT_PLACE;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.map_rd = 1'b1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/imhpq_dpath.sv
module imhpq_dpath #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32,
    parameter int OUT_W     = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  imhpq_pkg::cmd_t            cmd,
    output imhpq_pkg::sts_t            sts,
    input  logic [imhpq_pkg::IN_W-1:0] in_data,
    input  logic                       in_valid,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [OUT_W-1:0]           out_data
);
    import imhpq_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = SLOT_W + 2;
    localparam int ENT_W  = ID_W + KEY_WIDTH;
    localparam int MAP_W  = 1 + SLOT_W;
    localparam int KX_W   = (KEY_WIDTH > KEY_IN_W) ? KEY_IN_W : KEY_WIDTH;
    localparam int CLR_W  = $clog2(ID_SPACE) + 1;
    localparam int RES_W  = ST_W + ID_W + 1 + CNT_W + 1;

    // memories
    logic [ENT_W-1:0] heap_mem [CAPACITY];
    logic [MAP_W-1:0] map_mem  [ID_SPACE];
    logic [ENT_W-1:0] heap_q;
    logic [MAP_W-1:0] map_q;

    // item and working registers
    logic [OP_W-1:0]      op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [SLOT_W-1:0]    pos_reg;
    logic [ID_W-1:0]      e_id_reg;
    logic [KEY_WIDTH-1:0] e_key_reg;
    logic [ID_W-1:0]      l_id_reg;
    logic [KEY_WIDTH-1:0] l_key_reg;
    logic                 r_ok_reg;
    logic [ST_W-1:0]      status_reg;
    logic [ID_W-1:0]      min_id_reg;
    logic [CLR_W-1:0]     clr_reg;
    logic                 out_valid_reg;
    logic [RES_W-1:0]     res_reg;

    logic [OP_W-1:0]      in_op;
    logic [ID_W-1:0]      in_id;
    logic [KEY_WIDTH-1:0] in_key;
    logic [ID_W-1:0]      rd_id;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [IDX_W-1:0]     left_idx;
    logic [IDX_W-1:0]     right_idx;
    logic [IDX_W-1:0]     cnt_x;
    logic [SLOT_W-1:0]    parent_idx;
    logic                 left_in;
    logic                 right_in;
    logic                 take_l;
    logic                 take_r;
    logic [KEY_WIDTH-1:0] best_key;
    logic [ENT_W-1:0]     child_ent;
    logic [SLOT_W-1:0]    child_idx;
    logic [SLOT_W-1:0]    hrd_addr;
    logic                 heap_we;
    logic [SLOT_W-1:0]    heap_wa;
    logic [ENT_W-1:0]     heap_wd;
    logic                 map_we;
    logic [ID_W-1:0]      map_wa;
    logic [MAP_W-1:0]     map_wd;

    // input unpacking, key masked to the stored width
    assign in_op  = in_data[OP_W-1:0];
    assign in_id  = in_data[OP_W +: ID_W];
    assign in_key = KEY_WIDTH'(in_data[OP_W + ID_W +: KX_W]);

    assign rd_id  = heap_q[ENT_W-1:KEY_WIDTH];
    assign rd_key = heap_q[KEY_WIDTH-1:0];

    // tree index arithmetic
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IDX_W'(1);
    assign cnt_x      = IDX_W'(count_reg);
    assign parent_idx = (pos_reg - SLOT_W'(1)) >> 1;
    assign left_in    = left_idx < cnt_x;
    assign right_in   = right_idx < cnt_x;

    // sift-down child choice, left wins a tie
    assign take_l    = l_key_reg < e_key_reg;
    assign best_key  = take_l ? l_key_reg : e_key_reg;
    assign take_r    = r_ok_reg && (rd_key < best_key);
    assign child_ent = take_r ? heap_q : {l_id_reg, l_key_reg};
    assign child_idx = take_r ? right_idx[SLOT_W-1:0] : left_idx[SLOT_W-1:0];

    // heap read address
    always_comb
    begin
        unique case (cmd.hrd_sel)
            HRD_ROOT:   hrd_addr = '0;
            HRD_LAST:   hrd_addr = SLOT_W'(count_reg - CNT_W'(1));
            HRD_SLOT:   hrd_addr = map_q[SLOT_W-1:0];
            HRD_PARENT: hrd_addr = parent_idx;
            HRD_LEFT:   hrd_addr = left_idx[SLOT_W-1:0];
            HRD_RIGHT:  hrd_addr = right_idx[SLOT_W-1:0];
            default:    hrd_addr = '0;
        endcase
    end

    // memory write ports
    always_comb
    begin
        heap_we = 1'b0;
        heap_wa = pos_reg;
        heap_wd = {e_id_reg, e_key_reg};
        map_we  = 1'b0;
        map_wa  = e_id_reg;
        map_wd  = {1'b1, pos_reg};
        if (cmd.clr_step)
        begin
            map_we = 1'b1;
            map_wa = clr_reg[CLR_W-2:0];
            map_wd = '0;
        end
        else
        begin
            unique case (cmd.act)
                ACT_EX_MIN:
                begin
                    map_we = 1'b1;
                    map_wa = rd_id;
                    map_wd = '0;
                end
                ACT_PLACE:
                begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                end
                ACT_UP:
                begin
                    heap_we = 1'b1;
                    heap_wd = heap_q;
                    map_we  = 1'b1;
                    map_wa  = rd_id;
                end
                ACT_DN:
                begin
                    heap_we = 1'b1;
                    heap_wd = child_ent;
                    map_we  = 1'b1;
                    map_wa  = child_ent[ENT_W-1:KEY_WIDTH];
                end
                default:
                begin
                    heap_we = 1'b0;
                end
            endcase
        end
    end

    // heap store
    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        if (cmd.hrd)
        begin
            heap_q <= heap_mem[hrd_addr];
        end
    end

    // id to slot map
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        if (cmd.map_rd)
        begin
            map_q <= map_mem[id_reg];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + CLR_W'(1);
            end
            if (cmd.act == ACT_PUSH_INIT)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.act == ACT_EX_MIN)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            id_reg     <= in_id;
            key_reg    <= in_key;
            status_reg <= ST_DONE;
            min_id_reg <= '0;
        end
        if (cmd.set_st)
        begin
            status_reg <= cmd.st;
        end
        unique case (cmd.act)
            ACT_PUSH_INIT:
            begin
                e_id_reg  <= id_reg;
                e_key_reg <= key_reg;
                pos_reg   <= SLOT_W'(count_reg);
            end
            ACT_SLOT:
            begin
                pos_reg <= map_q[SLOT_W-1:0];
            end
            ACT_E_IN:
            begin
                e_id_reg  <= id_reg;
                e_key_reg <= key_reg;
            end
            ACT_EX_MIN:
            begin
                min_id_reg <= rd_id;
            end
            ACT_E_RD:
            begin
                e_id_reg  <= rd_id;
                e_key_reg <= rd_key;
                pos_reg   <= '0;
            end
            ACT_UP:
            begin
                pos_reg <= parent_idx;
            end
            ACT_LCAP:
            begin
                l_id_reg  <= rd_id;
                l_key_reg <= rd_key;
                r_ok_reg  <= right_in;
            end
            ACT_DN:
            begin
                pos_reg <= child_idx;
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
        if (cmd.res_load)
        begin
            res_reg <= {(count_reg == '0), count_reg, map_q[MAP_W-1], min_id_reg, status_reg};
        end
    end

    // status back to the controller
    always_comb
    begin
        sts.clr_done  = clr_reg[CLR_W-1];
        sts.map_valid = map_q[MAP_W-1];
        sts.full      = (count_reg >= CNT_W'(CAPACITY));
        sts.cnt_zero  = (count_reg == '0);
        sts.pos_zero  = (pos_reg == '0);
        sts.less_dk   = key_reg < rd_key;
        sts.less_up   = e_key_reg < rd_key;
        sts.left_in   = left_in;
        sts.dn_move   = take_l || take_r;
        sts.out_busy  = out_valid_reg && !out_ready;
        sts.op        = cmd.load ? in_op : op_reg;
        if (!in_valid && cmd.load)
        begin
            sts.op = op_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = OUT_W'(res_reg);

endmodule

>>> rtl/indexed_min_heap_priority_queue.sv
// channel   dir  fields (low bit first)
// s_axis    in   tdata: operation[1:0] item_id[11:2] key[43:12]
// m_axis    out  tdata: status, min_id, id_present, element_count, heap_empty
//
// lookup only reads the id map; push and decrease key climb the heap with
// a parent read and a compare per level, extract minimum descends with a
// left and a right child read and a compare per level; every heap level
// costs its reads and a compare on the single heap read port
// after reset the id map is cleared with s_tready low
// one item at a time; a result held in the output register stalls only
// the end of the following item
module indexed_min_heap_priority_queue #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // operation, item_id, key
    input  logic [imhpq_pkg::IN_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status, min_id, id_present, element_count, heap_empty
    output logic [((15 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);
    import imhpq_pkg::*;

    localparam int OUT_W = ((15 + $clog2(CAPACITY + 1) + 7) / 8) * 8;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    imhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .cmd      (cmd),
        .in_valid (s_tvalid),
        .in_ready (s_tready)
    );

    // heap store, map and result register
    imhpq_dpath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .OUT_W     (OUT_W)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .in_valid  (s_tvalid),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
